### hw/rtl/frac_pll_rate_calculator_core_assert.svh
// Assertion macros for the RTL files of the rate calculator, used by frpc_div.
`ifndef FRAC_PLL_RATE_CALCULATOR_CORE_ASSERT_SVH
`define FRAC_PLL_RATE_CALCULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FRPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/frpc_pkg.sv
package frpc_pkg;

    // Field widths.
    localparam int PARENT_W = 28;
    localparam int QUAD_W   = 30;
    localparam int TARGET_W = 32;
    localparam int X_W      = 36;
    localparam int FIELD_W  = 27;
    localparam int RATE_W   = 34;
    localparam int UNIT_W   = 11;
    localparam int PROD_W   = 57;
    localparam int SUM_W    = 58;

    // Predivider search length and index width.
    localparam int PDF_STEPS = 16;
    localparam int PDF_W     = 4;

    // Shared divider geometry.
    localparam int DIV_W = 57;
    localparam int DVS_W = 30;
    localparam int CNT_W = 6;

    // Constants of the arithmetic.
    localparam logic [PARENT_W-1:0] PARENT_RESET = 28'd24000000;
    localparam logic [FIELD_W-1:0]  FIXED_MFD    = 27'd999999;
    localparam logic [DVS_W-1:0]    MICRO_UNITS  = 30'd1000000;
    localparam logic [3:0]          MFI_MIN      = 4'd5;
    localparam logic [DIV_W-1:0]    MFI_MAX      = 57'd15;
    localparam logic [RATE_W-1:0]   RATE_MAX     = 34'h3_FFFF_FFFF;

    // Fraction unit floor(4*ref/1000000) equals floor((ref >> 4) / 15625).
    // The reciprocal ceil(2^38/15625) gives an exact quotient for 24-bit operands.
    localparam logic [FIELD_W-1:0]  UNIT_RECIP   = 27'd17592187;
    localparam int                  UNIT_SHIFT   = 38;

    // Configuration register indexes (word address).
    localparam logic REG_REF_FREQ = 1'b0;

    // Operation codes.
    localparam logic OP_ROUND  = 1'b0;
    localparam logic OP_RECALC = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UNIT_GO,
        ST_SRCH_GO,
        ST_SRCH_WAIT,
        ST_MFN_GO,
        ST_MFN_WAIT,
        ST_REF_GO,
        ST_REF_WAIT,
        ST_MUL_FRAC,
        ST_FRAC_GO,
        ST_FRAC_WAIT,
        ST_MUL_BASE,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic                op;
        logic [TARGET_W-1:0] target_rate;
        logic                doubler_on;
        logic [3:0]          pdf_in;
        logic [3:0]          mfi_in;
        logic [FIELD_W-1:0]  mfd_in;
        logic [FIELD_W-1:0]  mfn_in;
    } in_item_t;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_out;
        logic [3:0]         pdf_out;
        logic [3:0]         mfi_out;
        logic [FIELD_W-1:0] mfd_out;
        logic [FIELD_W-1:0] mfn_out;
        logic               invalid;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_resp_t;

endpackage

### hw/rtl/frac_pll_rate_calculator_core.sv
// Fractional-N PLL rate calculator.
// The s_ channel takes one request per transfer: s_tuser selects round (0) or
// recalc (1), s_tdata carries the target rate and the PLL fields. The m_ channel
// returns one result per request: the rate in hertz and the chosen fields in
// m_tdata, the invalid flag in m_tuser. The APB port holds the reference clock
// register at address 0; write it only while no request is in flight.
// All arithmetic runs through one restoring divider, one quotient bit per
// cycle, and one 30x27 multiplier under a sequencer; s_tready is high only
// while the sequencer is idle. A recalc request runs a 30-step and a 57-step
// division. A round request adds a reciprocal multiply for the fraction unit,
// one 36-step division per predivider tried (1 to 16) and a 30-step numerator
// division; invalid requests end earlier. Between consecutive requests the
// sequencer always returns to the idle state.
// A finished result sits in an output register; if the receiver stalls, the
// next request is still taken and runs until its own result is ready, then
// waits for the register to drain. Reset clears the sequencer and the output
// valid and loads the reference clock register with 24 MHz.
module frac_pll_rate_calculator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: target_rate[31:0], doubler_on, pdf_in[3:0], mfi_in[3:0],
    // mfd_in[26:0], mfn_in[26:0], one zero pad bit.
    input  logic [95:0] s_tdata,
    // s_tuser: op.
    input  logic        s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: rate_out[33:0], pdf_out[3:0], mfi_out[3:0], mfd_out[26:0],
    // mfn_out[26:0].
    output logic [95:0] m_tdata,
    // m_tuser: invalid.
    output logic        m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import frpc_pkg::*;

    logic [PARENT_W-1:0] ref_freq;
    in_item_t            s_item;
    div_req_t            div_req;
    div_resp_t           div_resp;
    result_t             res;
    logic                res_load;
    logic                out_free;

    result_t             out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    // Unpack the request transfer.
    assign s_item.op          = s_tuser;
    assign s_item.target_rate = s_tdata[31:0];
    assign s_item.doubler_on  = s_tdata[32];
    assign s_item.pdf_in      = s_tdata[36:33];
    assign s_item.mfi_in      = s_tdata[40:37];
    assign s_item.mfd_in      = s_tdata[67:41];
    assign s_item.mfn_in      = s_tdata[94:68];

    frpc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .ref_freq (ref_freq)
    );

    frpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    frpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ref_freq (ref_freq),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .div_req  (div_req),
        .div_resp (div_resp),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    // Output register: loads when empty or being drained in the same cycle.
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (res_load) begin
            out_next     = res;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // Pack the result transfer.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.mfn_out, out_reg.mfd_out, out_reg.mfi_out,
                       out_reg.pdf_out, out_reg.rate_out};
    assign m_tuser  = out_reg.invalid;

endmodule

### hw/rtl/frpc_cfg.sv
module frpc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [frpc_pkg::PARENT_W-1:0] ref_freq
);
    import frpc_pkg::*;

    logic [PARENT_W-1:0] ref_freq_reg;
    logic [PARENT_W-1:0] ref_freq_next;
    logic                wr_hit;

    // A write lands in the access phase of a transfer to the register word.
    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_REF_FREQ);

    always_comb begin
        ref_freq_next = ref_freq_reg;
        if (wr_hit) begin
            ref_freq_next = pwdata[PARENT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_freq_reg <= PARENT_RESET;
        end else begin
            ref_freq_reg <= ref_freq_next;
        end
    end

    // Read back the register, zero-extended; other words read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_REF_FREQ) begin
            prdata = {{(32-PARENT_W){1'b0}}, ref_freq_reg};
        end
    end

    assign ref_freq = ref_freq_reg;

endmodule

### hw/rtl/frpc_div.sv
`include "frac_pll_rate_calculator_core_assert.svh"

module frpc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  frpc_pkg::div_req_t  req,
    output frpc_pkg::div_resp_t resp
);
    import frpc_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DVS_W+1:0] diff;
    logic             neg;

    // One restoring step: trial subtract of the divisor from the shifted remainder.
    assign diff = {1'b0, r_reg, q_reg[DIV_W-1]} - {2'b00, dvs_reg};
    assign neg  = diff[DVS_W+1];

    // The dividend arrives left-aligned, so only the requested number of steps run.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            dvs_next  = req.divisor;
            r_next    = '0;
            q_next    = req.dividend;
        end else if (busy_reg) begin
            r_next   = neg ? {r_reg[DVS_W-2:0], q_reg[DIV_W-1]} : diff[DVS_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], ~neg};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvs_reg <= dvs_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = q_reg;
    assign resp.remainder = r_reg;

    // The sequencer must never launch a division while one is running.
    `FRPC_ASSERT_NOW(a_start_when_idle, aclk, aresetn, req.start, !busy_reg, "divider started while busy")
    // The completion flag is a single-cycle pulse after the last step.
    `FRPC_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg && !busy_reg, "done longer than one cycle")
    // A running division keeps going until its count reaches the last step.
    `FRPC_ASSERT_NEXT(a_busy_holds, aclk, aresetn, busy_reg && (cnt_reg != CNT_W'(1)) && !req.start, busy_reg && !done_reg, "divider stopped early")

endmodule

### hw/rtl/frpc_ctrl.sv
module frpc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [frpc_pkg::PARENT_W-1:0] ref_freq,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  frpc_pkg::in_item_t            s_item,
    output frpc_pkg::div_req_t            div_req,
    input  frpc_pkg::div_resp_t           div_resp,
    input  logic                          out_free,
    output logic                          res_load,
    output frpc_pkg::result_t             res
);
    import frpc_pkg::*;

    state_t state_reg, state_next;

    logic                op_reg, op_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic                dbl_reg, dbl_next;
    logic [PDF_W-1:0]    pdf_reg, pdf_next;
    logic [3:0]          mfi_reg, mfi_next;
    logic [FIELD_W-1:0]  mfd_reg, mfd_next;
    logic [FIELD_W-1:0]  mfn_reg, mfn_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [UNIT_W-1:0]   unit_reg, unit_next;
    logic [QUAD_W-1:0]   rem_reg, rem_next;
    logic [QUAD_W-1:0]   ref_reg, ref_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [RATE_W-1:0]   base_reg, base_next;
    logic                invalid_reg, invalid_next;

    logic                accept;
    logic [QUAD_W-1:0]   quad;
    logic [QUAD_W-1:0]   ref_src;
    logic [FIELD_W-1:0]  mag;
    logic [3:0]          mfi_eff;
    logic [QUAD_W-1:0]   mul_a;
    logic [FIELD_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [UNIT_W-1:0]   unit_calc;
    logic                srch_stop;
    logic                srch_over;
    logic [SUM_W-1:0]    sum;
    logic [RATE_W-1:0]   rate;

    assign accept = s_valid && s_ready;
    assign quad   = {ref_freq, 2'b00};

    // Reference after the doubler: twice the parent, or four times with the doubler on.
    assign ref_src = dbl_reg ? {ref_freq, 2'b00} : {1'b0, ref_freq, 1'b0};

    // Magnitude of the signed numerator field and the clamped multiplier.
    assign mag     = mfn_reg[FIELD_W-1] ? (~mfn_reg + 1'b1) : mfn_reg;
    assign mfi_eff = (mfi_reg < MFI_MIN) ? MFI_MIN : mfi_reg;

    // Shared multiplier: fraction unit by reciprocal, then numerator magnitude,
    // then the integer multiplier.
    assign mul_a = (state_reg == ST_UNIT_GO)
                 ? {{(QUAD_W-PARENT_W+4){1'b0}}, ref_freq[PARENT_W-1:4]} : ref_reg;
    assign mul_b = (state_reg == ST_UNIT_GO)  ? UNIT_RECIP
                 : (state_reg == ST_MUL_BASE) ? {{(FIELD_W-4){1'b0}}, mfi_eff} : mag;
    assign mul_p = {{(PROD_W-QUAD_W){1'b0}}, mul_a} * {{(PROD_W-FIELD_W){1'b0}}, mul_b};
    assign unit_calc = mul_p[UNIT_SHIFT+UNIT_W-1:UNIT_SHIFT];

    // The search ends at the first multiplier of five or more, or at the last predivider.
    assign srch_stop = (div_resp.quotient >= DIV_W'(MFI_MIN))
                    || (pdf_reg == PDF_W'(PDF_STEPS - 1));
    assign srch_over = div_resp.quotient > MFI_MAX;

    // Final combine of integer part and fraction, with clamping at both ends.
    assign sum = {1'b0, prod_reg} + {{(SUM_W-RATE_W){1'b0}}, base_reg};
    always_comb begin
        if (mfn_reg[FIELD_W-1]) begin
            if (prod_reg >= {{(PROD_W-RATE_W){1'b0}}, base_reg}) begin
                rate = '0;
            end else begin
                rate = base_reg - prod_reg[RATE_W-1:0];
            end
        end else if (sum > {{(SUM_W-RATE_W){1'b0}}, RATE_MAX}) begin
            rate = RATE_MAX;
        end else begin
            rate = sum[RATE_W-1:0];
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_item.op == OP_RECALC) ? ST_REF_GO : ST_UNIT_GO;
                end
            end
            ST_UNIT_GO: begin
                state_next = (unit_calc == '0) ? ST_FINAL : ST_SRCH_GO;
            end
            ST_SRCH_GO:  state_next = ST_SRCH_WAIT;
            ST_SRCH_WAIT: begin
                if (div_resp.done) begin
                    if (!srch_stop) begin
                        state_next = ST_SRCH_GO;
                    end else begin
                        state_next = srch_over ? ST_FINAL : ST_MFN_GO;
                    end
                end
            end
            ST_MFN_GO:   state_next = ST_MFN_WAIT;
            ST_MFN_WAIT: begin
                if (div_resp.done) begin
                    state_next = ST_REF_GO;
                end
            end
            ST_REF_GO:   state_next = ST_REF_WAIT;
            ST_REF_WAIT: begin
                if (div_resp.done) begin
                    state_next = ST_MUL_FRAC;
                end
            end
            ST_MUL_FRAC: state_next = ST_FRAC_GO;
            ST_FRAC_GO:  state_next = ST_FRAC_WAIT;
            ST_FRAC_WAIT: begin
                if (div_resp.done) begin
                    state_next = ST_MUL_BASE;
                end
            end
            ST_MUL_BASE: state_next = ST_FINAL;
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, divider launches and the result.
    always_comb begin
        s_ready          = 1'b0;
        res_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.steps    = '0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SRCH_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {x_reg, {(DIV_W-X_W){1'b0}}};
                div_req.divisor  = quad;
                div_req.steps    = CNT_W'(X_W);
            end
            ST_MFN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {rem_reg, {(DIV_W-QUAD_W){1'b0}}};
                div_req.divisor  = {{(DVS_W-UNIT_W){1'b0}}, unit_reg};
                div_req.steps    = CNT_W'(QUAD_W);
            end
            ST_REF_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {ref_src, {(DIV_W-QUAD_W){1'b0}}};
                div_req.divisor  = {{(DVS_W-PDF_W-1){1'b0}}, {1'b0, pdf_reg} + 1'b1};
                div_req.steps    = CNT_W'(QUAD_W);
            end
            ST_FRAC_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = {{(DVS_W-FIELD_W-1){1'b0}}, {1'b0, mfd_reg} + 1'b1};
                div_req.steps    = CNT_W'(DIV_W);
            end
            ST_FINAL: res_load = out_free;
            default: begin
            end
        endcase
    end

    // Result fields: all zero on an invalid request, settings only for a round request.
    always_comb begin
        res = '0;
        if (invalid_reg) begin
            res.invalid = 1'b1;
        end else begin
            res.rate_out = rate;
            if (op_reg == OP_ROUND) begin
                res.pdf_out = pdf_reg;
                res.mfi_out = mfi_reg;
                res.mfd_out = FIXED_MFD;
                res.mfn_out = mfn_reg;
            end
        end
    end

    // Working registers of the datapath.
    always_comb begin
        op_next      = op_reg;
        target_next  = target_reg;
        dbl_next     = dbl_reg;
        pdf_next     = pdf_reg;
        mfi_next     = mfi_reg;
        mfd_next     = mfd_reg;
        mfn_next     = mfn_reg;
        x_next       = x_reg;
        unit_next    = unit_reg;
        rem_next     = rem_reg;
        ref_next     = ref_reg;
        prod_next    = prod_reg;
        base_next    = base_reg;
        invalid_next = invalid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next      = s_item.op;
                    target_next  = s_item.target_rate;
                    dbl_next     = s_item.doubler_on;
                    pdf_next     = (s_item.op == OP_RECALC) ? s_item.pdf_in : '0;
                    mfi_next     = s_item.mfi_in;
                    mfd_next     = s_item.mfd_in;
                    mfn_next     = s_item.mfn_in;
                    x_next       = {{(X_W-TARGET_W){1'b0}}, s_item.target_rate};
                    invalid_next = 1'b0;
                end
            end
            ST_UNIT_GO: begin
                unit_next = unit_calc;
                if (unit_calc == '0) begin
                    invalid_next = 1'b1;
                end
            end
            ST_SRCH_WAIT: begin
                if (div_resp.done) begin
                    if (!srch_stop) begin
                        pdf_next = pdf_reg + 1'b1;
                        x_next   = x_reg + {{(X_W-TARGET_W){1'b0}}, target_reg};
                    end else if (srch_over) begin
                        invalid_next = 1'b1;
                    end else begin
                        mfi_next = div_resp.quotient[3:0];
                        rem_next = div_resp.remainder;
                    end
                end
            end
            ST_MFN_WAIT: begin
                if (div_resp.done) begin
                    mfn_next = div_resp.quotient[FIELD_W-1:0];
                    dbl_next = 1'b1;
                    mfd_next = FIXED_MFD;
                end
            end
            ST_REF_WAIT: begin
                if (div_resp.done) begin
                    ref_next = div_resp.quotient[QUAD_W-1:0];
                end
            end
            ST_MUL_FRAC: prod_next = mul_p;
            ST_FRAC_WAIT: begin
                if (div_resp.done) begin
                    prod_next = div_resp.quotient;
                end
            end
            ST_MUL_BASE: base_next = mul_p[RATE_W-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        target_reg  <= target_next;
        dbl_reg     <= dbl_next;
        pdf_reg     <= pdf_next;
        mfi_reg     <= mfi_next;
        mfd_reg     <= mfd_next;
        mfn_reg     <= mfn_next;
        x_reg       <= x_next;
        unit_reg    <= unit_next;
        rem_reg     <= rem_next;
        ref_reg     <= ref_next;
        prod_reg    <= prod_next;
        base_reg    <= base_next;
        invalid_reg <= invalid_next;
    end

endmodule
